/* hw/rtl/dppd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dppd_pkg
// Shared constants, types and codes of the page packet deframer.
// ----------------------------------------------------------------------------
package dppd_pkg;

  localparam int unsigned HEADER_WORDS = 32;
  localparam int unsigned PAGE_WORDS   = 524288;
  localparam int unsigned POS_W        = $clog2(PAGE_WORDS) + 1;
  localparam int unsigned LIM_W        = 34;
  localparam int unsigned LEN_W        = 16;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned TRL_W        = 3;
  localparam int unsigned VB_W         = 3;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_AW      = $clog2(FIFO_DEPTH);

  localparam logic [TRL_W-1:0] TRAILER_RESET = 3'd4;
  localparam logic [VB_W-1:0]  BYTES_PER_WORD = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_TSTAMP,
    PH_LENGTH,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    logic [WORD_W-1:0] payload_word;
    logic [VB_W-1:0]   valid_bytes;
    logic              end_of_packet;
    logic [LEN_W-1:0]  packet_bytes;
    logic              end_of_page;
    logic              page_number;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

/* hw/rtl/dppd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dppd_in_if / dppd_out_if
// Valid/ready channels for page words in and payload words out.
// ----------------------------------------------------------------------------
interface dppd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] page_word;
  logic        page_start;

  modport source (output valid, output page_word, output page_start, input ready);
  modport sink (input valid, input page_word, input page_start, output ready);
endinterface

interface dppd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] payload_word;
  logic [2:0]  valid_bytes;
  logic        end_of_packet;
  logic [15:0] packet_bytes;
  logic        end_of_page;
  logic        page_number;

  modport source (output valid, output payload_word, output valid_bytes,
                  output end_of_packet, output packet_bytes, output end_of_page,
                  output page_number, input ready);
  modport sink (input valid, input payload_word, input valid_bytes,
                input end_of_packet, input packet_bytes, input end_of_page,
                input page_number, output ready);
endinterface

/* hw/rtl/dppd_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dppd_parser
// Front end: accepts page words, tracks the page layout and classifies each
// word, pushing one result per delivered payload word into the queue.
// ----------------------------------------------------------------------------
module dppd_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  dppd_in_if.sink                    in_ch,
  input  logic                       cfg_wr_en,
  input  logic [dppd_pkg::TRL_W-1:0] cfg_wr_data,
  input  dppd_pkg::fifo_stat_t       stat,
  output dppd_pkg::push_t            push
);
  import dppd_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   limit_r, limit_nxt;
  logic [LEN_W-1:0]   btd_r, btd_nxt;
  logic [LEN_W-1:0]   skip_r, skip_nxt;
  logic [LEN_W-1:0]   cpb_r, cpb_nxt;
  logic               toggle_r, toggle_nxt;
  logic [TRL_W-1:0]   trailer_r;

  logic               accept;
  logic [POS_W-1:0]   pos_inc;
  logic               more_records;
  logic [LIM_W-1:0]   lim_full;
  logic [LEN_W-1:0]   len;
  logic [LEN_W:0]     len_pad;
  logic [LEN_W-1:0]   skip_calc;
  logic [LEN_W-1:0]   trl_ext;
  logic [VB_W-1:0]    vb;
  logic               closes;
  logic [LEN_W-1:0]   skip_dec;

  assign in_ch.ready = !stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign pos_inc      = pos_r + POS_W'(1);
  assign more_records = ({1'b0, pos_inc} + (POS_W+1)'(1)) < {1'b0, limit_r};
  assign lim_full     = {1'b0, in_ch.page_word, 1'b0} + LIM_W'(HEADER_WORDS);
  assign len          = in_ch.page_word[LEN_W-1:0];
  assign len_pad      = {1'b0, len} + (LEN_W+1)'(7);
  assign skip_calc    = LEN_W'({len_pad[LEN_W:3], 1'b0});
  assign trl_ext      = LEN_W'(trailer_r);
  assign vb           = (btd_r < LEN_W'(BYTES_PER_WORD)) ? btd_r[VB_W-1:0] : BYTES_PER_WORD;
  assign closes       = ({1'b0, pos_inc} + (POS_W+1)'(skip_r)) >= {1'b0, limit_r};
  assign skip_dec     = skip_r - LEN_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      pos_r     <= '0;
      limit_r   <= '0;
      btd_r     <= '0;
      skip_r    <= '0;
      cpb_r     <= '0;
      toggle_r  <= 1'b0;
      trailer_r <= TRAILER_RESET;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      limit_r  <= limit_nxt;
      btd_r    <= btd_nxt;
      skip_r   <= skip_nxt;
      cpb_r    <= cpb_nxt;
      toggle_r <= toggle_nxt;
      if (cfg_wr_en) begin
        trailer_r <= cfg_wr_data;
      end
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    limit_nxt  = limit_r;
    btd_nxt    = btd_r;
    skip_nxt   = skip_r;
    cpb_nxt    = cpb_r;
    toggle_nxt = toggle_r;
    push.valid              = 1'b0;
    push.data.payload_word  = in_ch.page_word;
    push.data.valid_bytes   = vb;
    push.data.end_of_packet = (btd_r == LEN_W'(vb));
    push.data.packet_bytes  = cpb_r;
    push.data.end_of_page   = closes;
    push.data.page_number   = ~toggle_r;
    if (accept) begin
      if (in_ch.page_start) begin
        toggle_nxt = !toggle_r;
        limit_nxt  = (lim_full > LIM_W'(PAGE_WORDS)) ? POS_W'(PAGE_WORDS) : lim_full[POS_W-1:0];
        pos_nxt    = '0;
        btd_nxt    = '0;
        skip_nxt   = '0;
        cpb_nxt    = '0;
        phase_nxt  = (in_ch.page_word == '0) ? PH_IDLE : PH_HEADER;
      end else if (phase_r != PH_IDLE) begin
        if (pos_inc >= POS_W'(PAGE_WORDS)) begin
          phase_nxt = PH_IDLE;
        end else begin
          pos_nxt = pos_inc;
          unique case (phase_r)
            PH_HEADER: begin
              if (pos_inc >= POS_W'(HEADER_WORDS - 1)) begin
                phase_nxt = more_records ? PH_TSTAMP : PH_IDLE;
              end
            end
            PH_TSTAMP: begin
              phase_nxt = PH_LENGTH;
            end
            PH_LENGTH: begin
              skip_nxt = skip_calc;
              btd_nxt  = (len > trl_ext) ? len - trl_ext : '0;
              cpb_nxt  = (len > trl_ext) ? len - trl_ext : '0;
              if (skip_calc == '0) begin
                phase_nxt = more_records ? PH_TSTAMP : PH_IDLE;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end
            PH_PAYLOAD: begin
              if (btd_r != '0) begin
                push.valid = 1'b1;
                btd_nxt    = btd_r - LEN_W'(vb);
              end
              skip_nxt = skip_dec;
              if (skip_dec == '0) begin
                phase_nxt = more_records ? PH_TSTAMP : PH_IDLE;
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
      end
    end
  end

endmodule

/* hw/rtl/dppd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dppd_fifo
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module dppd_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dppd_pkg::push_t      push,
  input  logic                 pop,
  output dppd_pkg::result_t    head,
  output dppd_pkg::fifo_stat_t stat
);
  import dppd_pkg::*;

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign stat.full  = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push.valid && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (FIFO_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push.data;
    end
  end

endmodule

/* hw/rtl/dppd_emitter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dppd_emitter
// Back end: moves queued results into the output register and presents them.
// ----------------------------------------------------------------------------
module dppd_emitter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dppd_pkg::result_t    head,
  input  dppd_pkg::fifo_stat_t stat,
  output logic                 pop,
  dppd_out_if.source           out_ch
);
  import dppd_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign pop = !stat.empty && (!valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= head;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.payload_word  = data_r.payload_word;
  assign out_ch.valid_bytes   = data_r.valid_bytes;
  assign out_ch.end_of_packet = data_r.end_of_packet;
  assign out_ch.packet_bytes  = data_r.packet_bytes;
  assign out_ch.end_of_page   = data_r.end_of_page;
  assign out_ch.page_number   = data_r.page_number;

endmodule

/* hw/rtl/dma_page_packet_deframer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_page_packet_deframer_top
// Receive page deframer: strips the page header and record framing and
// delivers packet payload words without their trailing check bytes.
// ----------------------------------------------------------------------------
// Takes one page word per cycle while the result queue has room and, once the
// first result has passed the queue and output register, gives one payload
// word per cycle while out_ch.ready is high. The parser never stalls a word, so
// the rate is set only by the four-entry result queue, which holds input ready
// low when full because the result side is stalled. Words of headers,
// timestamps, lengths and padding produce no result. Write cfg_wr_data
// (trailer bytes) only while the block is idle.
module dma_page_packet_deframer_top (
  input  logic                       clk,
  input  logic                       rst_n,
  dppd_in_if.sink                    in_ch,
  dppd_out_if.source                 out_ch,
  input  logic                       cfg_wr_en,
  input  logic [dppd_pkg::TRL_W-1:0] cfg_wr_data
);
  import dppd_pkg::*;

  push_t      push;
  fifo_stat_t stat;
  result_t    head;
  logic       pop;

  dppd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stat        (stat),
    .push        (push)
  );

  dppd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .stat  (stat)
  );

  dppd_emitter u_emitter (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .stat   (stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push.valid && stat.full))
    else $error("result pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty))
    else $error("result popped from an empty queue");

  a_push_needs_transaction: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (in_ch.valid && in_ch.ready && !in_ch.page_start))
    else $error("result produced without an accepted payload word");

  a_out_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");
`endif

endmodule

/* verif/tb_dma_page_packet_deframer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dma_page_packet_deframer_top
// Drives receive pages into the deframer and checks every payload word.
// A tracker mirrors the page parser and queues the payload words each
// accepted page word should yield. Every delivered word is compared field by
// field with the oldest queued word. Short directed pages come first. Random
// pages follow under each trailer setting and several idle/stall mixes. A
// final page with a saturated count carries a packet of the longest length
// and is cut short.
// ----------------------------------------------------------------------------
module tb_dma_page_packet_deframer_top;
  import dppd_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_WORDS   = 30;

  class payload_tracker;
    phase_t           parse_phase;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] limit;
    logic [LEN_W-1:0] bytes_left;
    logic [LEN_W-1:0] skip_left;
    logic [LEN_W-1:0] pkt_bytes;
    logic             toggle;
    logic [TRL_W-1:0] trailer;
    result_t          pending[$];
    int unsigned      errors;

    function new();
      parse_phase = PH_IDLE;
      position    = '0;
      limit       = '0;
      bytes_left  = '0;
      skip_left   = '0;
      pkt_bytes   = '0;
      toggle      = 1'b0;
      trailer     = TRAILER_RESET;
      errors      = 0;
    endfunction

    function void close_record(logic [POS_W-1:0] pos);
      parse_phase = (32'(pos) + 1 < 32'(limit)) ? PH_TSTAMP : PH_IDLE;
    endfunction

    function void take_page_word(logic [WORD_W-1:0] word, logic start);
      logic [LIM_W:0]   span;
      logic [POS_W-1:0] pos;
      int unsigned      len;
      logic [VB_W-1:0]  vb;
      result_t          r;
      if (start) begin
        span = {2'b00, word, 1'b0} + HEADER_WORDS;
        toggle = ~toggle;
        if (span > PAGE_WORDS) span = PAGE_WORDS;
        limit       = span[POS_W-1:0];
        position    = '0;
        bytes_left  = '0;
        skip_left   = '0;
        pkt_bytes   = '0;
        parse_phase = (word == '0) ? PH_IDLE : PH_HEADER;
        return;
      end
      if (parse_phase == PH_IDLE) return;
      pos = position + 1'b1;
      if (pos >= PAGE_WORDS) begin
        parse_phase = PH_IDLE;
        return;
      end
      position = pos;
      case (parse_phase)
        PH_HEADER: begin
          if (pos >= HEADER_WORDS - 1) close_record(pos);
        end
        PH_TSTAMP: begin
          parse_phase = PH_LENGTH;
        end
        PH_LENGTH: begin
          len        = word[LEN_W-1:0];
          skip_left  = 16'(((len + 7) >> 3) << 1);
          bytes_left = (len > trailer) ? 16'(len - trailer) : '0;
          pkt_bytes  = bytes_left;
          if (skip_left == '0) close_record(pos);
          else parse_phase = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (bytes_left != '0) begin
            vb = (bytes_left < BYTES_PER_WORD) ? bytes_left[VB_W-1:0] : BYTES_PER_WORD;
            r.end_of_page   = (32'(pos) + 32'(skip_left) >= 32'(limit));
            bytes_left      = bytes_left - vb;
            r.payload_word  = word;
            r.valid_bytes   = vb;
            r.end_of_packet = (bytes_left == '0);
            r.packet_bytes  = pkt_bytes;
            r.page_number   = ~toggle;
            pending.push_back(r);
          end
          skip_left = skip_left - 1'b1;
          if (skip_left == '0) close_record(pos);
        end
        default: begin
          parse_phase = PH_IDLE;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, seen);
      end
    endfunction

    function void match_payload(result_t seen);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: payload word 0x%0h expected none, got one", $time, seen.payload_word);
        return;
      end
      want = pending.pop_front();
      compare_field("payload_word", want.payload_word, seen.payload_word);
      compare_field("valid_bytes", want.valid_bytes, seen.valid_bytes);
      compare_field("end_of_packet", want.end_of_packet, seen.end_of_packet);
      compare_field("packet_bytes", want.packet_bytes, seen.packet_bytes);
      compare_field("end_of_page", want.end_of_page, seen.end_of_page);
      compare_field("page_number", want.page_number, seen.page_number);
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [TRL_W-1:0] cfg_wr_data;

  dppd_in_if  page_ch ();
  dppd_out_if payload_ch ();

  dma_page_packet_deframer_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (page_ch),
    .out_ch      (payload_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  payload_tracker   sb = new();
  result_t          observed;
  logic [LEN_W-1:0] len_plan[$];
  int unsigned      gap_pct;
  int unsigned      stall_pct;
  int unsigned      words_sent;
  int unsigned      quiet_cycles;
  logic [TRL_W-1:0] trailer_plan[8] = '{3'd0, 3'd7, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6, 3'd3};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    payload_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      payload_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && page_ch.valid && page_ch.ready) begin
      sb.take_page_word(page_ch.page_word, page_ch.page_start);
    end
    if (rst_n && payload_ch.valid && payload_ch.ready) begin
      observed = '{payload_word: payload_ch.payload_word, valid_bytes: payload_ch.valid_bytes,
                   end_of_packet: payload_ch.end_of_packet,
                   packet_bytes: payload_ch.packet_bytes, end_of_page: payload_ch.end_of_page,
                   page_number: payload_ch.page_number};
      sb.match_payload(observed);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (page_ch.valid && page_ch.ready) || (payload_ch.valid && payload_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin
        gap_pct = 0;
        stall_pct = 0;
      end
      1: begin
        gap_pct = 50;
        stall_pct = 0;
      end
      2: begin
        gap_pct = 0;
        stall_pct = 50;
      end
      default: begin
        gap_pct = 13;
        stall_pct = 13;
      end
    endcase
  endtask

  task automatic push_word(input logic [WORD_W-1:0] word, input logic start);
    while ($urandom_range(99) < gap_pct) begin
      page_ch.valid <= 1'b0;
      @(posedge clk);
    end
    page_ch.valid      <= 1'b1;
    page_ch.page_word  <= word;
    page_ch.page_start <= start;
    @(posedge clk);
    while (!page_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // hold the sender until every payload word is out, then let the block settle
  task automatic drain();
    page_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_trailer(input logic [TRL_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.trailer = value;
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 35) return 16'($urandom_range(0, sb.trailer + 5));
    if (roll < 85) return 16'($urandom_range(0, 48));
    if (roll < 97) return 16'($urandom_range(49, 256));
    return 16'($urandom_range(257, 1500));
  endfunction

  // cut counts page words including word 0; zero sends the whole page
  task automatic send_page(input logic [WORD_W-1:0] count, input int unsigned cut);
    logic [WORD_W-1:0] body[$];
    longint unsigned   limit;
    longint unsigned   pos;
    logic [LEN_W-1:0]  len;
    int unsigned       pad;
    push_word(count, 1'b1);
    if (count == '0) begin
      len_plan.delete();
      return;
    end
    limit = 2 * longint'(count) + HEADER_WORDS;
    if (limit > PAGE_WORDS) limit = PAGE_WORDS;
    repeat (HEADER_WORDS - 1) body.push_back($urandom);
    pos = HEADER_WORDS - 1;
    while (pos + 1 < limit && (cut == 0 || body.size() < cut)) begin
      if (len_plan.size() != 0) len = len_plan.pop_front();
      else len = pick_length();
      pad = ((int'(len) + 7) / 8) * 2;
      body.push_back($urandom);
      body.push_back({16'($urandom), len});
      repeat (pad) body.push_back($urandom);
      pos += 2 + pad;
    end
    len_plan.delete();
    foreach (body[i]) begin
      if (cut != 0 && i + 1 >= cut) break;
      push_word(body[i], 1'b0);
    end
  endtask

  task automatic random_page();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      send_page($urandom_range(1, 8), 0);
    end else if (pick < 80) begin
      send_page($urandom_range(1, 24), $urandom_range(2, 60));
    end else if (pick < 87) begin
      send_page('0, 0);
      repeat ($urandom_range(0, 3)) push_word($urandom, 1'b0);
    end else if (pick < 93) begin
      repeat ($urandom_range(1, 4)) push_word($urandom, 1'b0);
    end else begin
      send_page($urandom | 32'h0004_0000, $urandom_range(34, 50));
    end
  endtask

  initial begin
    int unsigned phase_base;
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    page_ch.valid      = 1'b0;
    page_ch.page_word  = '0;
    page_ch.page_start = 1'b0;
    words_sent         = 0;
    set_idling(0);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // words outside any page, then an empty page
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'h0000_0000, 1'b0);
    send_page('0, 0);
    push_word(32'hA5A5_A5A5, 1'b0);
    // zero length, length equal to trailer, one byte, record overrunning the page end
    len_plan = '{16'd0, 16'd4, 16'd5, 16'd13};
    send_page(32'd6, 0);
    // drop a packet part-way through
    len_plan = '{16'd20};
    send_page(32'd4, 36);
    send_page(32'hFFFF_FFFF, 40);
    send_page(32'h8000_0000, 45);
    send_page(32'd2, 0);

    for (int p = 0; p < 8; p++) begin
      drain();
      write_trailer(trailer_plan[p]);
      set_idling(p % 4);
      phase_base = words_sent;
      while (words_sent - phase_base < PHASE_WORDS) begin
        random_page();
        if (p == 2 && words_sent - phase_base < PHASE_WORDS / 2) drain();
      end
    end

    // saturated count: one packet of the longest length, cut short
    drain();
    write_trailer(3'd0);
    set_idling(0);
    len_plan.push_back(16'hFFFF);
    send_page(32'hFFFF_FFFF, 40);
    drain();

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/dppd_pkg.sv
hw/rtl/dppd_if.sv
hw/rtl/dppd_parser.sv
hw/rtl/dppd_fifo.sv
hw/rtl/dppd_emitter.sv
hw/rtl/dma_page_packet_deframer_top.sv
verif/tb_dma_page_packet_deframer_top.sv
